FILE: src/mag_pkg.sv
// ============================================================================
// mag_pkg - shared types and microcode for the multi-ant grid automaton
// Word layouts, command codes, sequencer steps and the control store.
// ============================================================================
package mag_pkg;

    // command codes on the input word
    localparam logic [1:0] CMD_STEP  = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_PLACE = 2'd2;

    // heading codes
    localparam logic [1:0] HEAD_UP    = 2'd0;
    localparam logic [1:0] HEAD_RIGHT = 2'd1;
    localparam logic [1:0] HEAD_DOWN  = 2'd2;
    localparam logic [1:0] HEAD_LEFT  = 2'd3;

    // turn amounts applied to a 2-bit heading
    localparam logic [1:0] TURN_RIGHT = 2'd1;
    localparam logic [1:0] TURN_LEFT  = 2'd3;

    localparam int HUE_W  = 8;
    localparam int CELL_D = HUE_W + 1;

    typedef struct packed {
        logic [1:0] cmd;
        logic [1:0] ant_index;
        logic [3:0] start_col;
        logic [3:0] start_row;
        logic [1:0] start_heading;
    } t_in_word;

    typedef struct packed {
        logic [3:0]       pixel_col;
        logic [3:0]       pixel_row;
        logic             pixel_lit;
        logic [HUE_W-1:0] pixel_hue;
        logic [1:0]       mover_index;
        logic             last_write;
    } t_out_word;

    typedef enum logic [2:0] {
        STEP_IDLE,
        STEP_RD_CUR,
        STEP_TOGGLE,
        STEP_TURN,
        STEP_CLEAR
    } t_step;

    typedef enum logic [1:0] {
        JMP_DISPATCH,
        JMP_GO,
        JMP_IF_MORE_ANTS,
        JMP_IF_MORE_CELLS
    } t_jmp;

    typedef struct packed {
        logic  accept;     // take a command word
        logic  rd_new;     // read the cell the ant moves onto
        logic  wr_toggle;  // write the toggled cell under the ant
        logic  wr_clear;   // sweep write of a dark cell
        logic  emit;       // load the result word
        logic  move;       // advance the ant one cell
        logic  turn;       // turn on the cell just read
        t_jmp  jmp;
        t_step next;
    } t_ctrl;

    // control store, one word per step
    function automatic t_ctrl ctrl_word(input t_step s);
        t_ctrl c;
        c = '0;
        c.jmp  = JMP_GO;
        c.next = STEP_IDLE;
        case (s)
            STEP_IDLE: begin
                c.accept = 1'b1;
                c.jmp    = JMP_DISPATCH;
            end
            STEP_RD_CUR: begin
                c.next = STEP_TOGGLE;
            end
            STEP_TOGGLE: begin
                c.wr_toggle = 1'b1;
                c.emit      = 1'b1;
                c.move      = 1'b1;
                c.rd_new    = 1'b1;
                c.next      = STEP_TURN;
            end
            STEP_TURN: begin
                c.turn = 1'b1;
                c.jmp  = JMP_IF_MORE_ANTS;
                c.next = STEP_RD_CUR;
            end
            STEP_CLEAR: begin
                c.wr_clear = 1'b1;
                c.jmp      = JMP_IF_MORE_CELLS;
                c.next     = STEP_CLEAR;
            end
            default: begin
                c.next = STEP_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage

FILE: src/multi_ant_grid_automaton.sv
// ============================================================================
// multi_ant_grid_automaton - several Langton ants on one wrapping grid
// Microcoded sequencer over a single-port-write, single-read cell memory.
// ============================================================================
// A word is taken when start is high and busy is low. A place command does
// not raise busy. A step command keeps busy high for three control steps per
// ant: read the ant's cell, write it back toggled while reading the cell it
// moves onto, then turn; the next word can be taken once busy is low. One
// pixel word per ant appears on o_word with o_strobe high for a single cycle;
// there is no back-pressure, so the receiver must take each word when it is
// shown. A clear command sweeps the cell memory one cell a cycle; the same
// sweep runs right after reset before the first word is taken.
module multi_ant_grid_automaton #(
    parameter int GRID_COLS = 16,
    parameter int GRID_ROWS = 16,
    parameter int ANT_COUNT = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  mag_pkg::t_in_word  i_word,
    output logic               busy,
    output logic               o_strobe,
    output mag_pkg::t_out_word o_word
);

    localparam int COL_W      = $clog2(GRID_COLS);
    localparam int ROW_W      = $clog2(GRID_ROWS);
    localparam int CELL_COUNT = GRID_COLS * GRID_ROWS;
    localparam int CELL_W     = $clog2(CELL_COUNT);
    localparam int ANT_W      = (ANT_COUNT > 1) ? $clog2(ANT_COUNT) : 1;

    // reduce a 4-bit coordinate into the grid by restoring subtraction
    function automatic logic [COL_W-1:0] wrap_col(input logic [3:0] v);
        logic [3:0] rem;
        rem = v;
        for (int k = 3; k >= 0; k--) begin
            if (32'(rem) >= (GRID_COLS << k)) begin
                rem = rem - 4'(GRID_COLS << k);
            end
        end
        return COL_W'(rem);
    endfunction

    function automatic logic [ROW_W-1:0] wrap_row(input logic [3:0] v);
        logic [3:0] rem;
        rem = v;
        for (int k = 3; k >= 0; k--) begin
            if (32'(rem) >= (GRID_ROWS << k)) begin
                rem = rem - 4'(GRID_ROWS << k);
            end
        end
        return ROW_W'(rem);
    endfunction

    function automatic logic [CELL_W-1:0] cell_addr(input logic [COL_W-1:0] col,
                                                    input logic [ROW_W-1:0] row);
        return CELL_W'(int'(row) * GRID_COLS + int'(col));
    endfunction

    // sequencer
    mag_pkg::t_step r_step, n_step;
    mag_pkg::t_ctrl ctrl;

    // datapath state
    logic [COL_W-1:0]          r_ant_col [ANT_COUNT];
    logic [ROW_W-1:0]          r_ant_row [ANT_COUNT];
    logic [1:0]                r_ant_head [ANT_COUNT];
    logic [ANT_W-1:0]          r_ant;
    logic [mag_pkg::HUE_W-1:0] r_hue;
    logic [CELL_W-1:0]         r_clr_addr;
    logic [mag_pkg::CELL_D-1:0] mem [CELL_COUNT];
    logic [mag_pkg::CELL_D-1:0] r_rd_data;

    logic                       accept;
    logic                       last_ant;
    logic                       last_cell;
    logic                       place_en;
    logic [ANT_W-1:0]           place_idx;
    logic [COL_W-1:0]           cur_col, new_col;
    logic [ROW_W-1:0]           cur_row, new_row;
    logic [1:0]                 cur_head;
    logic [CELL_W-1:0]          cur_addr, new_addr, rd_addr, wr_addr;
    logic                       wr_en;
    logic [mag_pkg::CELL_D-1:0] wr_data;
    logic                       cell_lit;

    assign ctrl      = mag_pkg::ctrl_word(r_step);
    assign busy      = (r_step != mag_pkg::STEP_IDLE);
    assign accept    = start && ctrl.accept;
    assign last_ant  = (32'(r_ant) == ANT_COUNT - 1);
    assign last_cell = (32'(r_clr_addr) == CELL_COUNT - 1);

    // next step
    always_comb begin
        n_step = r_step;
        case (ctrl.jmp)
            mag_pkg::JMP_DISPATCH: begin
                if (accept) begin
                    case (i_word.cmd)
                        mag_pkg::CMD_STEP:  n_step = mag_pkg::STEP_RD_CUR;
                        mag_pkg::CMD_CLEAR: n_step = mag_pkg::STEP_CLEAR;
                        default:            n_step = mag_pkg::STEP_IDLE;
                    endcase
                end
            end
            mag_pkg::JMP_GO: begin
                n_step = ctrl.next;
            end
            mag_pkg::JMP_IF_MORE_ANTS: begin
                n_step = last_ant ? mag_pkg::STEP_IDLE : ctrl.next;
            end
            mag_pkg::JMP_IF_MORE_CELLS: begin
                n_step = last_cell ? mag_pkg::STEP_IDLE : ctrl.next;
            end
            default: begin
                n_step = mag_pkg::STEP_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= mag_pkg::STEP_CLEAR;
        end else begin
            r_step <= n_step;
        end
    end

    // ant under service and where it moves
    assign cur_col  = r_ant_col[r_ant];
    assign cur_row  = r_ant_row[r_ant];
    assign cur_head = r_ant_head[r_ant];

    always_comb begin
        new_col = cur_col;
        new_row = cur_row;
        case (cur_head)
            mag_pkg::HEAD_UP: begin
                new_row = (32'(cur_row) == GRID_ROWS - 1) ? '0 : cur_row + 1'b1;
            end
            mag_pkg::HEAD_RIGHT: begin
                new_col = (32'(cur_col) == GRID_COLS - 1) ? '0 : cur_col + 1'b1;
            end
            mag_pkg::HEAD_DOWN: begin
                new_row = (cur_row == '0) ? ROW_W'(GRID_ROWS - 1) : cur_row - 1'b1;
            end
            default: begin
                new_col = (cur_col == '0) ? COL_W'(GRID_COLS - 1) : cur_col - 1'b1;
            end
        endcase
    end

    assign cur_addr = cell_addr(cur_col, cur_row);
    assign new_addr = cell_addr(new_col, new_row);
    assign rd_addr  = ctrl.rd_new ? new_addr : cur_addr;
    assign cell_lit = r_rd_data[mag_pkg::CELL_D-1];

    // dark becomes lit with the running hue, lit becomes dark; sweep writes store a dark cell
    assign wr_en   = ctrl.wr_toggle || ctrl.wr_clear;
    assign wr_addr = ctrl.wr_clear ? r_clr_addr : cur_addr;
    assign wr_data = (ctrl.wr_clear || cell_lit) ? '0 : {1'b1, r_hue};

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    // place command
    assign place_en  = accept && (i_word.cmd == mag_pkg::CMD_PLACE)
                       && (32'(i_word.ant_index) < ANT_COUNT);
    assign place_idx = ANT_W'(i_word.ant_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < ANT_COUNT; a++) begin
                r_ant_col[a]  <= '0;
                r_ant_row[a]  <= '0;
                r_ant_head[a] <= '0;
            end
            r_ant      <= '0;
            r_hue      <= '0;
            r_clr_addr <= '0;
        end else begin
            if (place_en) begin
                r_ant_col[place_idx]  <= wrap_col(i_word.start_col);
                r_ant_row[place_idx]  <= wrap_row(i_word.start_row);
                r_ant_head[place_idx] <= i_word.start_heading;
            end
            if (ctrl.move) begin
                r_ant_col[r_ant] <= new_col;
                r_ant_row[r_ant] <= new_row;
            end
            if (ctrl.turn) begin
                r_ant_head[r_ant] <= cur_head + (cell_lit ? mag_pkg::TURN_LEFT
                                                          : mag_pkg::TURN_RIGHT);
                if (last_ant) begin
                    r_ant <= '0;
                    r_hue <= r_hue + 1'b1;
                end else begin
                    r_ant <= r_ant + 1'b1;
                end
            end
            if (ctrl.wr_clear) begin
                r_clr_addr <= last_cell ? '0 : r_clr_addr + 1'b1;
            end
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= ctrl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.emit) begin
            o_word.pixel_col   <= 4'(cur_col);
            o_word.pixel_row   <= 4'(cur_row);
            o_word.pixel_lit   <= !cell_lit;
            o_word.pixel_hue   <= cell_lit ? '0 : r_hue;
            o_word.mover_index <= 2'(r_ant);
            o_word.last_write  <= last_ant;
        end
    end

    // checks
    a_strobe_single : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held longer than one cycle");

    a_strobe_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result shown while sequencer idle");

    a_step_starts : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_word.cmd == mag_pkg::CMD_STEP) |=> busy)
        else $error("step command did not start the sequencer");

    a_last_ends : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_word.last_write) |=> !busy)
        else $error("sequencer still busy after the last pixel word");

    a_no_idle_write : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> !wr_en)
        else $error("cell memory written while idle");

endmodule
